// ----- hdl/lsw_pkg.sv -----
package lsw_pkg;

	localparam int W          = 64;
	localparam int DEG_W      = 8;
	localparam int POW_DEPTH  = 64;
	localparam int POW_AW     = $clog2(POW_DEPTH);
	localparam int DIV_DW     = 8;
	localparam int STEP_W     = 7;
	localparam logic [DEG_W-1:0]  MAX_DEGREE  = 8'd255;
	localparam logic [STEP_W-1:0] SMALL_STEPS = 7'd8;
	localparam logic [STEP_W-1:0] BIG_STEPS   = 7'd64;

	typedef enum logic [1:0] {
		MU_ZERO,
		MU_POS,
		MU_NEG
	} mu_t;

	// Mobius function for 1..63; squareful values fall to zero
	function automatic mu_t mu_of(input logic [POW_AW-1:0] k);
		mu_t m;
		case (k) inside
			6'd1, 6'd6, 6'd10, 6'd14, 6'd15, 6'd21, 6'd22, 6'd26, 6'd33, 6'd34,
			6'd35, 6'd38, 6'd39, 6'd46, 6'd51, 6'd55, 6'd57, 6'd58, 6'd62:
				m = MU_POS;
			6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29,
			6'd30, 6'd31, 6'd37, 6'd41, 6'd42, 6'd43, 6'd47, 6'd53, 6'd59, 6'd61:
				m = MU_NEG;
			default:
				m = MU_ZERO;
		endcase
		return m;
	endfunction

	typedef struct packed {
		logic load;
		logic fail;
		logic set_one;
		logic pow_first;
		logic pow_write;
		logic mul_start;
		logic lvl_init;
		logic div_small;
		logic acc;
		logic d_inc;
		logic div_big;
		logic total_add;
		logic lvl_next;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic deg_zero;
		logic n_one;
		logic pw_bad;
		logic d_last;
		logic mul_run;
		logic div_busy;
		logic rem_zero;
		logic acc_ovf;
		logic d_eq_i;
		logic i_last;
		logic out_free;
	} st_t;

endpackage

// ----- hdl/lsw_ram.sv -----
module lsw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/lsw_div.sv -----
module lsw_div import lsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      dividend,
	input  logic [DIV_DW-1:0] divisor,
	input  logic [STEP_W-1:0] steps,
	output logic              busy,
	output logic [W-1:0]      quo,
	output logic [DIV_DW-1:0] rem
);

	logic [STEP_W-1:0] cnt_q;
	logic [W-1:0]      quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   rem_sh;
	logic              take;

	// restoring division, one quotient bit a cycle, MSB first
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[W-2:0], take};
			rem_q <= take ? DIV_DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_DW-1:0];
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- hdl/lsw_dp.sv -----
module lsw_dp import lsw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output st_t              st,
	input  logic [W-1:0]     alphabet_size,
	input  logic [DEG_W-1:0] depth,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [W-1:0]     length
);

	logic [W-1:0]     n_q;
	logic [DEG_W-1:0] deg_q;
	logic [DEG_W-1:0] i_q;
	logic [DEG_W-1:0] d_q;
	logic [W-1:0]     pw_q;
	logic             pw_ovf_q;
	logic [W-1:0]     part_q;
	logic [W-1:0]     total_q;
	logic [W-1:0]     length_q;
	logic             out_valid_q;

	// serial multiplier: pw * n, one bit of n a cycle
	logic             mul_run_q;
	logic [W-1:0]     mc_q;
	logic             mc_lost_q;
	logic [W-1:0]     mp_q;
	logic [W-1:0]     macc_q;
	logic             movf_q;
	logic [W:0]       msum;

	logic [W-1:0]      pw_rd;
	logic [W-1:0]      div_quo;
	logic [DIV_DW-1:0] div_rem;
	logic              div_busy;
	logic [W-1:0]      div_a;
	logic [DIV_DW-1:0] div_b;
	logic [STEP_W-1:0] div_n;
	logic              part_neg;
	logic [W-1:0]      part_mag;
	logic [W-1:0]      lvl_q;
	mu_t               mu;
	logic [W-1:0]      term;
	logic [W-1:0]      psum;

	assign msum = {1'b0, macc_q} + {1'b0, mc_q};

	lsw_ram #(.WIDTH(W), .DEPTH(POW_DEPTH)) u_pow (
		.clk   (clk),
		.we    (cmd.pow_write),
		.waddr (d_q[POW_AW-1:0]),
		.wdata (pw_q),
		.raddr (d_q[POW_AW-1:0]),
		.rdata (pw_rd)
	);

	assign part_neg = part_q[W-1];
	assign part_mag = part_neg ? W'(-part_q) : part_q;

	always_comb begin
		if (cmd.div_small) begin
			div_a = {i_q, {(W-DEG_W){1'b0}}};
			div_b = d_q;
			div_n = SMALL_STEPS;
		end else begin
			div_a = part_mag;
			div_b = i_q;
			div_n = BIG_STEPS;
		end
	end

	lsw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_small | cmd.div_big),
		.dividend (div_a),
		.divisor  (div_b),
		.steps    (div_n),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign lvl_q = part_neg ? W'(-div_quo) : div_quo;

	// quotient i/d is at most 63 once powers have passed the range check
	assign mu = mu_of(div_quo[POW_AW-1:0]);

	always_comb begin
		case (mu)
			MU_POS:  term = pw_rd;
			MU_NEG:  term = W'(-pw_rd);
			default: term = '0;
		endcase
	end

	assign psum = part_q + term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul_start) begin
				mul_run_q <= 1'b1;
			end else if (mul_run_q && mp_q == '0) begin
				mul_run_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= alphabet_size;
			deg_q   <= (depth > MAX_DEGREE) ? MAX_DEGREE : depth;
			total_q <= '0;
		end
		if (cmd.pow_first) begin
			pw_q     <= n_q;
			pw_ovf_q <= 1'b0;
			d_q      <= DEG_W'(1);
		end
		if (cmd.mul_start) begin
			mc_q      <= pw_q;
			mc_lost_q <= 1'b0;
			mp_q      <= n_q;
			macc_q    <= '0;
			movf_q    <= 1'b0;
			d_q       <= d_q + 1'b1;
		end else if (mul_run_q) begin
			if (mp_q == '0) begin
				pw_q     <= macc_q;
				pw_ovf_q <= movf_q;
			end else begin
				if (mp_q[0]) begin
					macc_q <= msum[W-1:0];
					if (msum[W] || mc_lost_q) begin
						movf_q <= 1'b1;
					end
				end
				mc_lost_q <= mc_lost_q | mc_q[W-1];
				mc_q      <= {mc_q[W-2:0], 1'b0};
				mp_q      <= {1'b0, mp_q[W-1:1]};
			end
		end
		if (cmd.lvl_init) begin
			i_q    <= DEG_W'(1);
			d_q    <= DEG_W'(1);
			part_q <= '0;
		end
		if (cmd.acc) begin
			part_q <= psum;
		end
		if (cmd.d_inc) begin
			d_q <= d_q + 1'b1;
		end
		if (cmd.total_add) begin
			total_q <= total_q + lvl_q;
		end
		if (cmd.lvl_next) begin
			i_q    <= i_q + 1'b1;
			d_q    <= DEG_W'(1);
			part_q <= '0;
		end
		if (cmd.fail) begin
			total_q <= '0;
		end
		if (cmd.set_one) begin
			total_q <= W'(1);
		end
		if (cmd.emit) begin
			length_q <= total_q;
		end
	end

	always_comb begin
		st          = '0;
		st.n_zero   = n_q == '0;
		st.deg_zero = deg_q == '0;
		st.n_one    = n_q == W'(1);
		st.pw_bad   = pw_ovf_q | pw_q[W-1];
		st.d_last   = d_q == deg_q;
		st.mul_run  = mul_run_q;
		st.div_busy = div_busy;
		st.rem_zero = div_rem == '0;
		st.acc_ovf  = (part_q[W-1] == term[W-1]) && (psum[W-1] != part_q[W-1]);
		st.d_eq_i   = d_q == i_q;
		st.i_last   = i_q == deg_q;
		st.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign length    = length_q;

endmodule

// ----- hdl/lsw_ctrl.sv -----
module lsw_ctrl import lsw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  st_t  st,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_PWCHK,
		S_MUL,
		S_DIV,
		S_DIVW,
		S_ACC,
		S_NEXT,
		S_LDIV,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.n_zero || st.deg_zero) begin
					cmd.fail = 1'b1;
					state_d  = S_OUT;
				end else if (st.n_one) begin
					// every level but the first sums to zero
					cmd.set_one = 1'b1;
					state_d     = S_OUT;
				end else begin
					cmd.pow_first = 1'b1;
					state_d       = S_PWCHK;
				end
			end
			S_PWCHK: begin
				if (st.pw_bad) begin
					cmd.fail = 1'b1;
					state_d  = S_OUT;
				end else begin
					cmd.pow_write = 1'b1;
					if (st.d_last) begin
						cmd.lvl_init = 1'b1;
						state_d      = S_DIV;
					end else begin
						cmd.mul_start = 1'b1;
						state_d       = S_MUL;
					end
				end
			end
			S_MUL: begin
				if (!st.mul_run) begin
					state_d = S_PWCHK;
				end
			end
			S_DIV: begin
				cmd.div_small = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (!st.div_busy) begin
					state_d = st.rem_zero ? S_ACC : S_NEXT;
				end
			end
			S_ACC: begin
				if (st.acc_ovf) begin
					cmd.fail = 1'b1;
					state_d  = S_OUT;
				end else begin
					cmd.acc = 1'b1;
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				if (st.d_eq_i) begin
					cmd.div_big = 1'b1;
					state_d     = S_LDIV;
				end else begin
					cmd.d_inc = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_LDIV: begin
				if (!st.div_busy) begin
					cmd.total_add = 1'b1;
					if (st.i_last) begin
						state_d = S_OUT;
					end else begin
						cmd.lvl_next = 1'b1;
						state_d      = S_DIV;
					end
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != S_IDLE;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !st.mul_run && !st.div_busy)
		else $error("arithmetic unit busy while idle");

	a_acc_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> !st.div_busy && $past(state_q) == S_DIVW)
		else $error("term added before divisor test finished");

	a_mul_owned: assert property (@(posedge clk) disable iff (!arst_n)
		st.mul_run |-> state_q == S_MUL)
		else $error("multiplier running outside power phase");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE && !cmd.emit)
		else $error("result emitted twice");

endmodule

// ----- hdl/log_signature_length_witt.sv -----
// Log signature length by the summed Witt formula.
// Input channel: alphabet_size and depth, taken when in_valid is high and
// in_stall low. One item is worked at a time; in_stall stays high from the
// cycle after acceptance until the result has been moved into the output
// register, and the next item can be taken in the cycle after that.
// Output channel: length, held with out_valid until out_stall is low. A
// result waiting there does not block the next input item; a second result
// waits in the controller until the output register frees up.
// Sequence: zero input or alphabet size one go straight to the output
// step, and a first power already out of range fails before any product.
// Otherwise each power n^d is formed in the bit-serial multiplier, which
// works through the b bits of n (at most 32 once n^2 is in range); each
// candidate divisor d of level i is tried in the 8-bit divider, with an
// accumulate step added when it divides; and each level ends with the
// 64-step division by i. Depth 62 is the deepest that passes the range check.
// Reset clears the controller and the output valid; the power store needs
// no clearing as each entry is written before it is read.
module log_signature_length_witt import lsw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [W-1:0]     alphabet_size,
	input  logic [DEG_W-1:0] depth,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [W-1:0]     length
);

	cmd_t cmd;
	st_t  st;

	lsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	lsw_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.alphabet_size (alphabet_size),
		.depth         (depth),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.length        (length)
	);

endmodule

// ----- bench/testbench.sv -----
module testbench;
	import lsw_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [W-1:0]     alphabet_size;
	logic [DEG_W-1:0] depth;
	logic             out_valid;
	logic             out_stall;
	logic [W-1:0]     length;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int N_RANDOM       = 78;

	typedef struct {
		logic [W-1:0]     n;
		logic [DEG_W-1:0] deg;
		bit               typed;
		logic [W-1:0]     want;
	} row_t;

	logic [W-1:0] length_q[$];
	logic [W-1:0] typed_q[$];
	bit           typed_flag_q[$];
	int           n_errors;
	int           idle_cycles;
	bit           timed_out;
	bit           rx_busy;

	log_signature_length_witt i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.alphabet_size(alphabet_size), .depth(depth),
		.out_valid(out_valid), .out_stall(out_stall),
		.length(length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// n^e by square-and-multiply; 0 when any needed product leaves 64 bits
	function automatic logic [W-1:0] power_or_zero(logic [W-1:0] b, logic [W-1:0] e);
		logic [2*W-1:0] prod;
		logic [W-1:0]   acc;
		acc = W'(1);
		while (e != 0) begin
			if (e[0]) begin
				prod = acc * {{W{1'b0}}, b};
				if (prod[2*W-1:W] != 0)
					return '0;
				acc = prod[W-1:0];
			end
			e = e >> 1;
			if (e != 0) begin
				prod = b * {{W{1'b0}}, b};
				if (prod[2*W-1:W] != 0)
					return '0;
				b = prod[W-1:0];
			end
		end
		return acc;
	endfunction

	function automatic int mobius(int k);
		int sgn;
		sgn = 1;
		for (int f = 2; f * f <= k; f++) begin
			if (k % f == 0) begin
				k = k / f;
				if (k % f == 0)
					return 0;
				sgn = -sgn;
			end
		end
		if (k > 1)
			sgn = -sgn;
		return sgn;
	endfunction

	function automatic logic [W-1:0] witt_length(logic [W-1:0] n, logic [DEG_W-1:0] deg_in);
		logic [W-1:0] total;
		logic [W-1:0] p;
		longint       part;
		longint       term;
		longint       top;
		longint       bottom;
		int           deg;
		int           m;
		top = 64'sh7fffffffffffffff;
		bottom = 64'sh8000000000000000;
		total = '0;
		deg = int'(deg_in);
		if (n == 0 || deg == 0)
			return '0;
		if (deg > int'(MAX_DEGREE))
			deg = int'(MAX_DEGREE);
		for (int i = 1; i <= deg; i++) begin
			part = 0;
			for (int d = 1; d <= i; d++) begin
				if (i % d != 0)
					continue;
				p = power_or_zero(n, W'(d));
				if (p == 0 || p > 64'h7fffffffffffffff)
					return '0;
				m = mobius(i / d);
				term = 0;
				if (m == 1)
					term = longint'(p);
				else if (m == -1)
					term = -longint'(p);
				if ((term > 0 && part > top - term) || (term < 0 && part < bottom - term))
					return '0;
				part += term;
			end
			total += W'(part / longint'(i));
		end
		return total;
	endfunction

	task automatic send_item(logic [W-1:0] n, logic [DEG_W-1:0] deg, bit typed,
			logic [W-1:0] want);
		int gap;
		in_valid      <= 1'b1;
		alphabet_size <= n;
		depth         <= deg;
		typed_q      = {typed_q, want};
		typed_flag_q = {typed_flag_q, typed};
		do @(posedge clk); while (in_stall);
		// bursts: lower valid only when a gap follows
		if ($urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// expectation taken at acceptance
	always @(posedge clk) begin
		logic [W-1:0] pred;
		if (arst_n && in_valid && !in_stall) begin
			pred = witt_length(alphabet_size, depth);
			if (typed_flag_q.pop_front() && typed_q[0] != pred) begin
				n_errors++;
				if (n_errors <= 10)
					$display("table mismatch n=%0d deg=%0d table=%0d predicted=%0d",
						alphabet_size, depth, typed_q[0], pred);
			end
			void'(typed_q.pop_front());
			length_q = {length_q, pred};
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			idle_cycles <= 0;
			rx_busy     <= 1'b0;
		end else begin
			// receiver: stall spells that come and go, with stall-free stretches
			if ($urandom_range(0, 15) == 0)
				rx_busy <= ~rx_busy;
			out_stall <= rx_busy ? ($urandom_range(0, 1) == 1) : 1'b0;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && !out_stall) begin
				if (length_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected length %0d", length);
				end else begin
					if (length !== length_q[0]) begin
						n_errors++;
						if (n_errors <= 10)
							$display("length mismatch: expected %0d got %0d",
								length_q[0], length);
					end
					void'(length_q.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		row_t         dir_rows[$];
		logic [W-1:0] n;
		logic [DEG_W-1:0] deg;
		int           sel;
		n_errors      = 0;
		timed_out     = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		alphabet_size = '0;
		depth         = '0;
		dir_rows = '{
			'{64'd0, 8'd0, 1, 64'd0},
			'{64'd0, 8'd255, 1, 64'd0},
			'{64'd5, 8'd0, 1, 64'd0},
			'{64'd1, 8'd255, 1, 64'd1},
			'{64'd1, 8'd1, 1, 64'd1},
			'{64'd2, 8'd1, 1, 64'd2},
			'{64'd2, 8'd2, 1, 64'd3},
			'{64'hffffffffffffffff, 8'd1, 1, 64'd0},
			'{64'h8000000000000000, 8'd3, 1, 64'd0},
			'{64'h7fffffffffffffff, 8'd1, 1, 64'h7fffffffffffffff},
			'{64'h7fffffffffffffff, 8'd2, 0, 64'd0},
			'{64'hffffffff, 8'd2, 0, 64'd0},
			'{64'h100000000, 8'd2, 0, 64'd0},
			'{64'd2, 8'd62, 0, 64'd0},
			'{64'd2, 8'd63, 1, 64'd0},
			'{64'd2, 8'd255, 1, 64'd0},
			'{64'd3, 8'd6, 0, 64'd0},
			'{64'd3, 8'd40, 0, 64'd0},
			'{64'd10, 8'd12, 0, 64'd0},
			'{64'd1290, 8'd6, 0, 64'd0},
			'{64'd2097151, 8'd3, 0, 64'd0},
			'{64'haaaaaaaaaaaaaaaa, 8'd170, 0, 64'd0},
			'{64'h5555555555555555, 8'd85, 0, 64'd0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[k])
			send_item(dir_rows[k].n, dir_rows[k].deg, dir_rows[k].typed, dir_rows[k].want);

		// hold off until every expected length has come out
		in_valid <= 1'b0;
		do @(posedge clk); while (length_q.size() != 0 || typed_q.size() != 0);

		for (int k = 0; k < N_RANDOM; k++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				n   = W'($urandom_range(2, 40));
				deg = DEG_W'($urandom_range(0, 10));
			end else if (sel < 8) begin
				n   = {$urandom, $urandom};
				deg = DEG_W'($urandom);
			end else if (sel == 8) begin
				n   = W'($urandom_range(0, 1));
				deg = DEG_W'($urandom);
			end else begin
				n   = W'($urandom_range(2, 5));
				deg = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(10, 30));
			end
			send_item(n, deg, 0, 64'd0);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (length_q.size() != 0);
		repeat (100) @(posedge clk);
		if (n_errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
